[rtl/core/cau_pkg.sv]
// Shared types, constants and the arctangent table for the complex arithmetic unit.
package cau_pkg;

  localparam int PART_WIDTH = 16;
  localparam int RES_WIDTH  = 33;
  localparam int STEPS      = 32;
  localparam int IDX_WIDTH  = 5;
  localparam int SQ_WIDTH   = 2 * PART_WIDTH;
  localparam int SQ_STEPS   = PART_WIDTH;
  localparam int XY_WIDTH   = 58;
  localparam int Z_WIDTH    = 36;
  localparam int SCALE      = 55 - PART_WIDTH;
  localparam int LATENCY    = STEPS + 2;

  localparam logic [2:0] FUNC_ADD  = 3'd0;
  localparam logic [2:0] FUNC_MUL  = 3'd1;
  localparam logic [2:0] FUNC_CONJ = 3'd2;
  localparam logic [2:0] FUNC_MOD  = 3'd3;
  localparam logic [2:0] FUNC_PHS  = 3'd4;

  typedef struct packed {
    logic                        valid;
    logic [2:0]                  func;
    logic signed [RES_WIDTH-1:0] pre_re;
    logic signed [RES_WIDTH-1:0] pre_im;
    logic [SQ_WIDTH-1:0]         sq_rem;
    logic [SQ_WIDTH-1:0]         sq_root;
    logic signed [XY_WIDTH-1:0]  x;
    logic signed [XY_WIDTH-1:0]  y;
    logic signed [Z_WIDTH-1:0]   z;
    logic                        ph_axis;
    logic signed [RES_WIDTH-1:0] ph_axis_val;
  } beat_t;

  function automatic logic signed [Z_WIDTH-1:0] atan_turn(input logic [IDX_WIDTH-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0: v = 32'h20000000;  5'd1: v = 32'h12E4051E;  5'd2: v = 32'h09FB385B;
      5'd3: v = 32'h051111D4;  5'd4: v = 32'h028B0D43;  5'd5: v = 32'h0145D7E1;
      5'd6: v = 32'h00A2F61E;  5'd7: v = 32'h00517C55;  5'd8: v = 32'h0028BE53;
      5'd9: v = 32'h00145F2F;  5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3; 5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D; 5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518; 5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146; 5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029; 5'd25: v = 32'h00000014; 5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005; 5'd28: v = 32'h00000003; 5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001; default: v = 32'h00000000;
    endcase
    return signed'({{(Z_WIDTH-32){1'b0}}, v});
  endfunction

endpackage

[rtl/core/cau_front.sv]
// Entry stage: products, sums, conjugate, squared modulus and CORDIC set-up.
module cau_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load,
  input  logic [2:0]                           func,
  input  logic signed [cau_pkg::PART_WIDTH-1:0] a_re,
  input  logic signed [cau_pkg::PART_WIDTH-1:0] a_im,
  input  logic signed [cau_pkg::PART_WIDTH-1:0] b_re,
  input  logic signed [cau_pkg::PART_WIDTH-1:0] b_im,
  output cau_pkg::beat_t                       beat
);
  localparam int PW = cau_pkg::PART_WIDTH;
  localparam int RW = cau_pkg::RES_WIDTH;
  localparam int XW = cau_pkg::XY_WIDTH;
  localparam int ZW = cau_pkg::Z_WIDTH;

  logic signed [2*PW:0]  p_rr, p_ii, p_ri, p_ir, sq_r, sq_i;
  logic signed [2*PW+1:0] mul_re, mul_im;
  logic [2*PW+1:0]        sq_sum;
  logic signed [XW-1:0]   xs, ys;
  cau_pkg::beat_t         beat_next;

  always_comb begin
    p_rr   = (2*PW+1)'(a_re * b_re);
    p_ii   = (2*PW+1)'(a_im * b_im);
    p_ri   = (2*PW+1)'(a_re * b_im);
    p_ir   = (2*PW+1)'(a_im * b_re);
    sq_r   = (2*PW+1)'(a_re * a_re);
    sq_i   = (2*PW+1)'(a_im * a_im);
    mul_re = (2*PW+2)'(p_rr) - (2*PW+2)'(p_ii);
    mul_im = (2*PW+2)'(p_ri) + (2*PW+2)'(p_ir);
    sq_sum = (2*PW+2)'(unsigned'(sq_r)) + (2*PW+2)'(unsigned'(sq_i));
    xs     = XW'(a_re) <<< cau_pkg::SCALE;
    ys     = XW'(a_im) <<< cau_pkg::SCALE;

    beat_next         = '0;
    beat_next.valid   = load && !rst;
    beat_next.func    = func;
    case (func)
      cau_pkg::FUNC_ADD: begin
        beat_next.pre_re = RW'(a_re) + RW'(b_re);
        beat_next.pre_im = RW'(a_im) + RW'(b_im);
      end
      cau_pkg::FUNC_MUL: begin
        beat_next.pre_re = RW'(mul_re);
        beat_next.pre_im = RW'(mul_im);
      end
      cau_pkg::FUNC_CONJ: begin
        beat_next.pre_re = RW'(a_re);
        beat_next.pre_im = -RW'(a_im);
      end
      default: ;
    endcase
    beat_next.sq_rem  = cau_pkg::SQ_WIDTH'(sq_sum);
    beat_next.sq_root = '0;
    // Vectors in the left half-plane are turned through pi before the CORDIC.
    if (a_re < 0) begin
      beat_next.x = -xs;
      beat_next.y = -ys;
      beat_next.z = (a_im > 0) ? (ZW'(1) <<< 31) : -(ZW'(1) <<< 31);
    end else begin
      beat_next.x = xs;
      beat_next.y = ys;
      beat_next.z = '0;
    end
    beat_next.ph_axis     = (a_im == 0) || (a_re == 0);
    if (a_im == 0)
      beat_next.ph_axis_val = (a_re < 0) ? RW'(32768) : '0;
    else
      beat_next.ph_axis_val = (a_im > 0) ? RW'(16384) : -RW'(16384);
  end

  always_ff @(posedge clk) begin
    beat <= beat_next;
  end
endmodule

[rtl/core/cau_cell.sv]
// One cell of the chain: a CORDIC vectoring step and, in the first SQ_STEPS cells, a square-root digit step.
module cau_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [cau_pkg::IDX_WIDTH-1:0]   idx,
  input  cau_pkg::beat_t                  beat_in,
  output cau_pkg::beat_t                  beat_out
);
  localparam int SW = cau_pkg::SQ_WIDTH;

  logic signed [cau_pkg::XY_WIDTH-1:0] dx, dy;
  logic [SW-1:0]                       bit_w, trial;
  cau_pkg::beat_t                      beat_next;

  always_comb begin
    beat_next = beat_in;
    beat_next.valid = beat_in.valid && !rst;
    dx = beat_in.y >>> idx;
    dy = beat_in.x >>> idx;
    if (beat_in.y > 0) begin
      beat_next.x = beat_in.x + dx;
      beat_next.y = beat_in.y - dy;
      beat_next.z = beat_in.z + cau_pkg::atan_turn(idx);
    end else begin
      beat_next.x = beat_in.x - dx;
      beat_next.y = beat_in.y + dy;
      beat_next.z = beat_in.z - cau_pkg::atan_turn(idx);
    end
    // Each of the first SQ_STEPS cells settles one bit of the root.
    bit_w = (SW'(1) << (SW - 2)) >> {idx, 1'b0};
    trial = beat_in.sq_root + bit_w;
    if ({1'b0, idx} < (cau_pkg::IDX_WIDTH+1)'(cau_pkg::SQ_STEPS)) begin
      if (beat_in.sq_rem >= trial) begin
        beat_next.sq_rem  = beat_in.sq_rem - trial;
        beat_next.sq_root = (beat_in.sq_root >> 1) + bit_w;
      end else begin
        beat_next.sq_root = beat_in.sq_root >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    beat_out <= beat_next;
  end
endmodule

[rtl/core/complex_arithmetic_unit.sv]
// Top level of the complex arithmetic unit: entry stage, cell chain and result register.
// The unit takes one beat in every cycle and never raises busy after reset has been
// released. Every result appears on res_re and res_im with done high once its start beat
// has passed through one entry stage, 32 cells of the CORDIC and square-root chain,
// and one result register. Results leave in issue order and must be taken as they come.
module complex_arithmetic_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [2:0]                            func,
  input  logic signed [cau_pkg::PART_WIDTH-1:0] a_re,
  input  logic signed [cau_pkg::PART_WIDTH-1:0] a_im,
  input  logic signed [cau_pkg::PART_WIDTH-1:0] b_re,
  input  logic signed [cau_pkg::PART_WIDTH-1:0] b_im,
  output logic                                  done,
  output logic signed [cau_pkg::RES_WIDTH-1:0]  res_re,
  output logic signed [cau_pkg::RES_WIDTH-1:0]  res_im
);
  localparam int RW = cau_pkg::RES_WIDTH;
  localparam int ZW = cau_pkg::Z_WIDTH;

  cau_pkg::beat_t chain [cau_pkg::STEPS+1];
  cau_pkg::beat_t last;
  logic [ZW-1:0]  z_mag;
  logic [ZW-1:0]  z_rnd;
  logic signed [RW-1:0] phase, res_re_next, res_im_next;

  cau_front u_front (
    .clk(clk), .rst(rst), .load(start && !busy), .func(func),
    .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im), .beat(chain[0])
  );

  for (genvar g = 0; g < cau_pkg::STEPS; g++) begin : g_cell
    cau_cell u_cell (
      .clk(clk), .rst(rst), .idx(cau_pkg::IDX_WIDTH'(g)),
      .beat_in(chain[g]), .beat_out(chain[g+1])
    );
  end

  assign last = chain[cau_pkg::STEPS];

  always_comb begin
    z_mag = last.z[ZW-1] ? ZW'(-last.z) : ZW'(last.z);
    z_rnd = (z_mag + ZW'(32768)) >> 16;
    if (last.ph_axis)
      phase = last.ph_axis_val;
    else if (last.z[ZW-1])
      phase = -RW'(z_rnd);
    else
      phase = RW'(z_rnd);
    res_re_next = '0;
    res_im_next = '0;
    case (last.func) inside
      cau_pkg::FUNC_ADD, cau_pkg::FUNC_MUL, cau_pkg::FUNC_CONJ: begin
        res_re_next = last.pre_re;
        res_im_next = last.pre_im;
      end
      cau_pkg::FUNC_MOD: res_re_next = RW'(last.sq_root);
      cau_pkg::FUNC_PHS: res_re_next = phase;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    res_re <= res_re_next;
    res_im <= res_im_next;
    if (rst) begin
      done <= 1'b0;
      busy <= 1'b1;
    end else begin
      done <= last.valid;
      busy <= 1'b0;
    end
  end
endmodule

[rtl/core/cau_checker.sv]
// Port-level checks for the complex arithmetic unit and the bind that attaches them.
module cau_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  start,
  input logic                                  busy,
  input logic [2:0]                            func,
  input logic signed [cau_pkg::PART_WIDTH-1:0] a_re,
  input logic signed [cau_pkg::PART_WIDTH-1:0] a_im,
  input logic                                  done,
  input logic signed [cau_pkg::RES_WIDTH-1:0]  res_re,
  input logic signed [cau_pkg::RES_WIDTH-1:0]  res_im
);
  a_idle_after_reset: assert property (@(posedge clk) !rst |=> !busy)
    else $error("busy raised outside reset");

  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##34 done)
    else $error("accepted beat gave no result after 34 cycles");

  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func[2] && (func[1] || func[0])) |-> ##34 (res_re == 0 && res_im == 0))
    else $error("unused function code gave a non-zero result");

  a_conj: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func == cau_pkg::FUNC_CONJ) |->
      ##34 (res_re == $past(a_re, 34) && res_im == -$past(a_im, 34)))
    else $error("conjugate result wrong");
endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
  .a_re(a_re), .a_im(a_im), .done(done), .res_re(res_re), .res_im(res_im)
);

[sim/tb.sv]
// Self-checking testbench for the complex arithmetic unit: directed table, then random beats.
`timescale 1ns / 100ps

module tb;

  // Codes the unit leaves unused; they must give a zero result.
  localparam logic [2:0] FUNC_SPARE5 = 3'd5;
  localparam logic [2:0] FUNC_SPARE6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE7 = 3'd7;
  localparam int RANDOM_BEATS = 1250;

  typedef logic signed [cau_pkg::RES_WIDTH-1:0] res_t;
  typedef logic signed [cau_pkg::PART_WIDTH-1:0] part_t;

  typedef struct packed {
    res_t re;
    res_t im;
  } cplx_res_t;

  typedef struct {
    logic [2:0] func;
    part_t      a_re;
    part_t      a_im;
    part_t      b_re;
    part_t      b_im;
    logic       typed;
    res_t       want_re;
    res_t       want_im;
  } row_t;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [2:0] func;
  part_t      a_re, a_im, b_re, b_im;
  logic       done;
  res_t       res_re, res_im;

  // Expected result travelling with the beat currently driven.
  logic       row_typed;
  cplx_res_t  row_want;

  cplx_res_t  pending_results[$];
  int         beats_taken;
  int         fails;

  complex_arithmetic_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
    .done(done), .res_re(res_re), .res_im(res_im)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Arctangent of 2^-i, in units of 2^32 per turn.
  localparam longint ARCTAN_STEP[32] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
    64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
    64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005,
    64'h00000003, 64'h00000001, 64'h00000001, 64'h00000000
  };

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(root);
  endfunction

  function automatic longint vector_angle(longint re, longint im);
    longint x, y, z, dx, dy;
    if (im == 0) return (re < 0) ? 32768 : 0;
    if (re == 0) return (im > 0) ? 16384 : -16384;
    x = re <<< (55 - cau_pkg::PART_WIDTH);
    y = im <<< (55 - cau_pkg::PART_WIDTH);
    z = 0;
    // Fold the left half-plane over, starting the angle at plus or minus a half turn.
    if (x < 0) begin
      x = -x;
      y = -y;
      z = (im > 0) ? (64'sd1 <<< 31) : -(64'sd1 <<< 31);
    end
    for (int i = 0; i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        z = z + ARCTAN_STEP[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - ARCTAN_STEP[i];
      end
    end
    if (z >= 0) return (z + 32768) >>> 16;
    return -(((-z) + 32768) >>> 16);
  endfunction

  function automatic cplx_res_t complex_result(logic [2:0] f, part_t ar, part_t ai,
                                               part_t br, part_t bi);
    longint xr, xi, yr, yi, re, im;
    cplx_res_t r;
    xr = ar;
    xi = ai;
    yr = br;
    yi = bi;
    re = 0;
    im = 0;
    case (f)
      cau_pkg::FUNC_ADD: begin
        re = xr + yr;
        im = xi + yi;
      end
      cau_pkg::FUNC_MUL: begin
        re = xr * yr - xi * yi;
        im = xr * yi + xi * yr;
      end
      cau_pkg::FUNC_CONJ: begin
        re = xr;
        im = -xi;
      end
      cau_pkg::FUNC_MOD: re = int_sqrt(longint'(xr * xr + xi * xi));
      cau_pkg::FUNC_PHS: re = vector_angle(xr, xi);
      default: ;
    endcase
    r.re = re[cau_pkg::RES_WIDTH-1:0];
    r.im = im[cau_pkg::RES_WIDTH-1:0];
    return r;
  endfunction

  // Results are compared and new beats recorded at the rising edge.
  always @(posedge clk) begin
    cplx_res_t want;
    if (!rst) begin
      if (done) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result re=%0d im=%0d", res_re, res_im);
          fails++;
        end else begin
          want = pending_results.pop_front();
          if (res_re !== want.re) begin
            $error("res_re: expected %0d, got %0d", want.re, res_re);
            fails++;
          end
          if (res_im !== want.im) begin
            $error("res_im: expected %0d, got %0d", want.im, res_im);
            fails++;
          end
        end
      end
      if (start && !busy) begin
        if (row_typed) pending_results.push_back(row_want);
        else pending_results.push_back(complex_result(func, a_re, a_im, b_re, b_im));
        beats_taken++;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat was taken.
  task automatic drive_beat(row_t r);
    int seen;
    seen = beats_taken;
    start <= 1'b1;
    func <= r.func;
    a_re <= r.a_re;
    a_im <= r.a_im;
    b_re <= r.b_re;
    b_im <= r.b_im;
    row_typed <= r.typed;
    row_want <= '{re: r.want_re, im: r.want_im};
    do @(negedge clk); while (beats_taken == seen);
  endtask

  function automatic part_t pick_part();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 16'sh7FFF;
      2: return 16'sh8000;
      3: return part_t'(int'($urandom_range(0, 16)) - 8);
      default: return part_t'($urandom);
    endcase
  endfunction

  function automatic row_t row(logic [2:0] f, int ar, int ai, int br, int bi,
                               logic typed = 1'b0, longint wr = 0, longint wi = 0);
    row_t r;
    r.func = f;
    r.a_re = part_t'(ar);
    r.a_im = part_t'(ai);
    r.b_re = part_t'(br);
    r.b_im = part_t'(bi);
    r.typed = typed;
    r.want_re = res_t'(wr);
    r.want_im = res_t'(wi);
    return r;
  endfunction

  initial begin
    row_t plan[$];
    row_t r;
    int burst;
    bit drained;
    rst = 1'b1;
    start = 1'b0;
    func = cau_pkg::FUNC_ADD;
    a_re = '0;
    a_im = '0;
    b_re = '0;
    b_im = '0;
    row_typed = 1'b0;
    row_want = '0;
    beats_taken = 0;
    fails = 0;
    drained = 1'b0;

    plan.push_back(row(cau_pkg::FUNC_ADD, 32767, 32767, 32767, 32767, 1, 65534, 65534));
    plan.push_back(row(cau_pkg::FUNC_ADD, -32768, -32768, -32768, -32768, 1, -65536, -65536));
    plan.push_back(row(cau_pkg::FUNC_ADD, 256, -512, 128, 64));
    plan.push_back(row(cau_pkg::FUNC_MUL, -32768, -32768, -32768, -32768, 1, 0,
                       64'sd2147483648));
    plan.push_back(row(cau_pkg::FUNC_MUL, 32767, -32768, -32768, 32767));
    plan.push_back(row(cau_pkg::FUNC_MUL, 32767, 32767, 32767, -32768));
    plan.push_back(row(cau_pkg::FUNC_CONJ, -32768, -32768, 0, 0, 1, -32768, 32768));
    plan.push_back(row(cau_pkg::FUNC_CONJ, 32767, 32767, 0, 0, 1, 32767, -32767));
    plan.push_back(row(cau_pkg::FUNC_MOD, -32768, -32768, 0, 0, 1, 46340, 0));
    plan.push_back(row(cau_pkg::FUNC_MOD, 0, 0, 0, 0, 1, 0, 0));
    plan.push_back(row(cau_pkg::FUNC_MOD, 3, -4, 0, 0, 1, 5, 0));
    plan.push_back(row(cau_pkg::FUNC_PHS, 0, 0, 0, 0, 1, 0, 0));
    plan.push_back(row(cau_pkg::FUNC_PHS, 5, 0, 0, 0, 1, 0, 0));
    plan.push_back(row(cau_pkg::FUNC_PHS, -5, 0, 0, 0, 1, 32768, 0));
    plan.push_back(row(cau_pkg::FUNC_PHS, -32768, 0, 0, 0, 1, 32768, 0));
    plan.push_back(row(cau_pkg::FUNC_PHS, 0, 7, 0, 0, 1, 16384, 0));
    plan.push_back(row(cau_pkg::FUNC_PHS, 0, -32768, 0, 0, 1, -16384, 0));
    plan.push_back(row(cau_pkg::FUNC_PHS, 1, 1, 0, 0));
    plan.push_back(row(cau_pkg::FUNC_PHS, -32768, 1, 0, 0));
    plan.push_back(row(cau_pkg::FUNC_PHS, -32768, -1, 0, 0));
    plan.push_back(row(cau_pkg::FUNC_PHS, 32767, -32768, 0, 0));
    plan.push_back(row(FUNC_SPARE5, 123, 456, 789, -1, 1, 0, 0));
    plan.push_back(row(FUNC_SPARE6, -1, -1, -1, -1, 1, 0, 0));
    plan.push_back(row(FUNC_SPARE7, 32767, -32768, 32767, -32768, 1, 0, 0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) drive_beat(plan[i]);

    for (int n = 0; n < RANDOM_BEATS; ) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && n < RANDOM_BEATS; k++, n++) begin
        r = row(3'($urandom_range(0, 7)), 0, 0, 0, 0);
        r.a_re = pick_part();
        r.a_im = pick_part();
        r.b_re = pick_part();
        r.b_im = pick_part();
        drive_beat(r);
      end
      if (!drained && n >= RANDOM_BEATS / 2) begin
        // Let the pipeline drain completely before carrying on.
        drained = 1'b1;
        start <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end else if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(negedge clk);
    repeat (cau_pkg::LATENCY + 8) @(negedge clk);
    if (fails == 0) begin
      $display("PASS complex_arithmetic_unit");
    end else begin
      $display("FAIL complex_arithmetic_unit");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL complex_arithmetic_unit");
    $finish;
  end

endmodule
